FILE: rtl/core/aesrt_pkg.sv
// ----------------------------------------------------------------------------
// aesrt_pkg
// Types, opcodes, GF(2^8) helpers and S-box tables for the AES round transform unit.
// ----------------------------------------------------------------------------
package aesrt_pkg;

  typedef enum logic [2:0] {
    OP_SUB_BYTES     = 3'd0,
    OP_SHIFT_ROWS    = 3'd1,
    OP_MIX_COLS      = 3'd2,
    OP_INV_SUB_BYTES = 3'd3,
    OP_INV_SHIFT     = 3'd4,
    OP_INV_MIX_COLS  = 3'd5,
    OP_ADD_KEY       = 3'd6,
    OP_PASS          = 3'd7
  } op_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;

  // multiply by x modulo 0x11B
  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t t;
    p = '0;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ t;
      t = xtime(t);
    end
    gf_mul = p;
  endfunction

  function automatic byte_t gf_inv(input byte_t a);
    byte_t r;
    byte_t b;
    r = 8'h01;
    b = a;
    // a^254: exponent bits 1..7 set
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    gf_inv = r;
  endfunction

  function automatic byte_t rotl(input byte_t x, input int n);
    rotl = byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic byte_t sbox_fwd(input byte_t x);
    byte_t b;
    b = gf_inv(x);
    sbox_fwd = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t sbox_inv(input byte_t x);
    sbox_inv = gf_inv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
  endfunction

  typedef byte_t [255:0] lut_t;

  function automatic lut_t build_sbox(input logic inv);
    lut_t t;
    for (int i = 0; i < 256; i++)
      t[i] = inv ? sbox_inv(byte_t'(i)) : sbox_fwd(byte_t'(i));
    build_sbox = t;
  endfunction

  localparam lut_t SBOX     = build_sbox(1'b0);
  localparam lut_t SBOX_INV = build_sbox(1'b1);

endpackage

FILE: rtl/core/aesrt_if.sv
// ----------------------------------------------------------------------------
// aesrt_req_if / aesrt_rsp_if
// Valid/ready channels of the AES round transform unit.
// ----------------------------------------------------------------------------
interface aesrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] state_lo;
  logic [63:0] state_hi;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  modport source (output valid, req_type, state_lo, state_hi, key_lo, key_hi,
                  input ready);
  modport sink (input valid, req_type, state_lo, state_hi, key_lo, key_hi,
                output ready);
endinterface

interface aesrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  modport source (output valid, result_lo, result_hi, input ready);
  modport sink (input valid, result_lo, result_hi, output ready);
endinterface

FILE: rtl/core/aes_round_transform_unit.sv
// ----------------------------------------------------------------------------
// aes_round_transform_unit
// Applies one AES transform to a 16-byte state per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req  : sink channel carrying an opcode, the state and the round key.
//   rsp  : source channel carrying the transformed state.
//   State bytes are row-major (byte 4*row+col), byte k at bits 8k+7..8k.
//   Opcodes: SubBytes, ShiftRows, MixColumns, their inverses, AddRoundKey
//   (key applied transposed); the unused code passes the state through.
// Flow: the input register loads at the accepting edge; the result register
//   loads from it, through one level of byte-parallel logic, once the output
//   stage is empty or drained, and rsp.valid rises when it holds the result.
// Throughput: one transaction per cycle while rsp.ready is high; a stage may
//   take a new item whenever its successor moves or is empty.
// Reset: clears both stage valid flags; no results are pending afterward.
// Stall: when rsp.ready is low the result holds and the input stage keeps
//   accepting until both stages are full, then req.ready drops.
// ----------------------------------------------------------------------------
module aes_round_transform_unit (
  input logic clk,
  input logic rst,
  aesrt_req_if.sink   req,
  aesrt_rsp_if.source rsp
);
  import aesrt_pkg::*;

  logic   in_valid;
  op_t    in_op;
  state_t in_state;
  state_t in_key;
  logic   out_valid;
  state_t out_state;
  state_t res;
  logic   out_adv;
  logic   in_adv;

  assign out_adv   = in_valid && (!out_valid || rsp.ready);
  assign in_adv    = req.valid && req.ready;
  assign req.ready = !in_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) in_valid <= req.valid;
      if (out_adv) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      in_op    <= op_t'(req.req_type);
      in_state <= state_t'({req.state_hi, req.state_lo});
      in_key   <= state_t'({req.key_hi, req.key_lo});
    end
    if (out_adv) out_state <= res;
  end

  always_comb begin
    res = in_state;
    unique case (in_op)
      OP_SUB_BYTES:
        for (int i = 0; i < 16; i++) res[i] = SBOX[in_state[i]];
      OP_INV_SUB_BYTES:
        for (int i = 0; i < 16; i++) res[i] = SBOX_INV[in_state[i]];
      OP_SHIFT_ROWS:
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            res[4*r+c] = in_state[4*r + ((c + r) & 3)];
      OP_INV_SHIFT:
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            res[4*r+c] = in_state[4*r + ((c + 4 - r) & 3)];
      OP_MIX_COLS:
        for (int j = 0; j < 4; j++)
          for (int i = 0; i < 4; i++)
            res[4*i+j] = xtime(in_state[4*i+j])
                       ^ xtime(in_state[4*((i+1)&3)+j]) ^ in_state[4*((i+1)&3)+j]
                       ^ in_state[4*((i+2)&3)+j] ^ in_state[4*((i+3)&3)+j];
      OP_INV_MIX_COLS:
        for (int j = 0; j < 4; j++)
          for (int i = 0; i < 4; i++)
            res[4*i+j] = gf_mul(8'h0e, in_state[4*i+j])
                       ^ gf_mul(8'h0b, in_state[4*((i+1)&3)+j])
                       ^ gf_mul(8'h0d, in_state[4*((i+2)&3)+j])
                       ^ gf_mul(8'h09, in_state[4*((i+3)&3)+j]);
      OP_ADD_KEY:
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            res[4*r+c] = in_state[4*r+c] ^ in_key[4*c+r];
      OP_PASS: res = in_state;
      default: res = in_state;
    endcase
  end

  assign rsp.valid     = out_valid;
  assign rsp.result_lo = out_state[7:0];
  assign rsp.result_hi = out_state[15:8];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_state))
    else $error("result changed while stalled");
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !rsp.ready |-> !req.ready)
    else $error("accepted into a full pipeline");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_adv |=> out_valid)
    else $error("advanced item lost");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_adv |=> in_valid)
    else $error("accepted item lost");

endmodule
